[src/pwm_divider_wrap_from_frequency_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the PWM divider and wrap calculator
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef PWM_DIVIDER_WRAP_FROM_FREQUENCY_ASSERT_SVH
`define PWM_DIVIDER_WRAP_FROM_FREQUENCY_ASSERT_SVH

// Property sampled on clk_i, switched off while rst_ni is low
`define PDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold on a clock edge outside reset
`define PDW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/pdw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_pkg
// Shared types and constants of the PWM divider and wrap calculator.
// ----------------------------------------------------------------------------
package pdw_pkg;

  localparam int unsigned ClockHzReset     = 32'd125000000;
  localparam int unsigned MaxPeriodDefault = 65535;
  localparam int unsigned MinDiv16Default  = 16;
  localparam int unsigned MaxDiv16Default  = 4095;

  localparam int unsigned HzW    = 32;
  localparam int unsigned Div16W = 12;
  localparam int unsigned PerW   = 16;
  localparam int unsigned TotW   = 37;  // clock*16 plus half the target
  localparam int unsigned WideW  = 38;  // total plus a rounding term

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_FAST = 2'd2,
    ST_TOO_SLOW = 2'd3
  } status_e;

endpackage

[src/pdw_target_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_target_if
// Request channel carrying one target PWM frequency.
// ----------------------------------------------------------------------------
interface pdw_target_if;
  logic        valid;
  logic        ready;
  logic [31:0] tgt_freq;

  modport source (output valid, output tgt_freq, input ready);
  modport sink   (input valid, input tgt_freq, output ready);
endinterface

[src/pdw_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_result_if
// Result channel carrying status, divider and wrap value.
// ----------------------------------------------------------------------------
interface pdw_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  div_whole;
  logic [3:0]  div_part;
  logic [15:0] wrap;

  modport source (output valid, output status, output div_whole, output div_part,
                  output wrap, input ready);
  modport sink   (input valid, input status, input div_whole, input div_part,
                  input wrap, output ready);
endinterface

[src/pdw_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_div_pipe
// Restoring divider, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
module pdw_div_pipe #(
  parameter int unsigned NumW = 37,
  parameter int unsigned DenW = 32,
  parameter int unsigned SbW  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [SbW-1:0]  sb_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [SbW-1:0]  sb_o
);

  logic            valid_q [NumW];
  logic [DenW-1:0] rem_q   [NumW];
  logic [NumW-1:0] num_q   [NumW];
  logic [NumW-1:0] quo_q   [NumW];
  logic [DenW-1:0] den_q   [NumW];
  logic [SbW-1:0]  sb_q    [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            vin;
    logic [DenW-1:0] rin;
    logic [NumW-1:0] nin;
    logic [NumW-1:0] qin;
    logic [DenW-1:0] din;
    logic [SbW-1:0]  sin;
    logic [DenW:0]   shifted;
    logic [DenW:0]   diff;
    logic            ge;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign nin = num_i;
      assign qin = '0;
      assign din = den_i;
      assign sin = sb_i;
    end else begin : g_next
      assign vin = valid_q[s-1];
      assign rin = rem_q[s-1];
      assign nin = num_q[s-1];
      assign qin = quo_q[s-1];
      assign din = den_q[s-1];
      assign sin = sb_q[s-1];
    end

    // bring down the next numerator bit and try the subtraction
    assign shifted = {rin, nin[NumW-1]};
    assign diff    = shifted - {1'b0, din};
    assign ge      = ~diff[DenW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DenW-1:0] : shifted[DenW-1:0];
        num_q[s] <= {nin[NumW-2:0], 1'b0};
        quo_q[s] <= {qin[NumW-2:0], ge};
        den_q[s] <= din;
        sb_q[s]  <= sin;
      end
    end
  end

  assign valid_o = valid_q[NumW-1];
  assign quo_o   = quo_q[NumW-1];
  assign sb_o    = sb_q[NumW-1];

endmodule

[src/pwm_divider_wrap_from_frequency.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_divider_wrap_from_frequency
// Target frequency to 8.4 clock divider and counter wrap value.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req_i     in   tgt_freq
// rsp_o     out  status, div_whole, div_part, wrap
// cfg       in   cfg_we_i / cfg_wdata_i -> input clock setting
//
// One request a cycle enters while the output is not stalled; the pipeline is
// two bit-per-stage dividers (total, period) and five single-register stages;
// the divider comes from a constant reciprocal multiply.
// All stages advance together; a stalled result holds the whole pipeline.
// Reset clears every valid bit and loads the input clock setting with 125 MHz.
// ----------------------------------------------------------------------------
`include "pwm_divider_wrap_from_frequency_assert.svh"

module pwm_divider_wrap_from_frequency import pdw_pkg::*; #(
  parameter int unsigned MaxPeriodCounts = MaxPeriodDefault,
  parameter int unsigned MinDiv16        = MinDiv16Default,
  parameter int unsigned MaxDiv16        = MaxDiv16Default
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HzW-1:0]    cfg_wdata_i,
  pdw_target_if.sink        req_i,
  pdw_result_if.source      rsp_o
);

  // Reciprocal of the period limit, exact for every numerator below 2^CeilW
  localparam longint unsigned SlowBound = longint'(MaxDiv16) * longint'(MaxPeriodCounts);
  localparam int unsigned     CeilW     = $clog2(SlowBound + longint'(MaxPeriodCounts));
  localparam int unsigned     RecipK    = CeilW + $clog2(MaxPeriodCounts);
  localparam longint unsigned RecipM    =
    ((64'd1 << RecipK) + longint'(MaxPeriodCounts) - 64'd1) / longint'(MaxPeriodCounts);
  localparam int unsigned     RecipW    = $clog2(RecipM + 64'd1);
  localparam int unsigned     ProdW     = CeilW + RecipW;

  logic [HzW-1:0] clock_q;
  logic           adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= HzW'(ClockHzReset);
    end else if (cfg_we_i) begin
      clock_q <= cfg_wdata_i;
    end
  end

  assign adv         = ~rsp_o.valid | rsp_o.ready;
  assign req_i.ready = adv;

  // Stage A: rounded numerator for total
  logic            a_valid_q;
  logic [TotW-1:0] a_num_q;
  logic [HzW-1:0]  a_den_q;
  logic            a_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_num_q <= {1'b0, clock_q, 4'b0000} + TotW'(req_i.tgt_freq >> 1);
      a_den_q <= req_i.tgt_freq;
      a_inv_q <= (clock_q == '0) || (req_i.tgt_freq == '0);
    end
  end

  logic            d1_valid;
  logic [TotW-1:0] d1_quo;
  logic            d1_inv;

  pdw_div_pipe #(.NumW(TotW), .DenW(HzW), .SbW(1)) u_div_total (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(a_valid_q), .num_i(a_num_q), .den_i(a_den_q), .sb_i(a_inv_q),
    .valid_o(d1_valid), .quo_o(d1_quo), .sb_o(d1_inv)
  );

  // Stage B: ceiling numerator for the divider, flag totals too small or too large for it
  logic             b_valid_q;
  logic [CeilW-1:0] b_num_q;
  logic [TotW-1:0]  b_total_q;
  logic             b_inv_q;
  logic             b_fast_q;
  logic             b_slow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_num_q   <= CeilW'(d1_quo) + CeilW'(MaxPeriodCounts - 1);
      b_total_q <= d1_quo;
      b_inv_q   <= d1_inv;
      b_fast_q  <= d1_quo < TotW'(MinDiv16);
      b_slow_q  <= d1_quo > TotW'(SlowBound);
    end
  end

  // Stage M: multiply by the reciprocal of the period limit
  logic             m_valid_q;
  logic [ProdW-1:0] m_prod_q;
  logic [TotW-1:0]  m_total_q;
  logic             m_inv_q;
  logic             m_fast_q;
  logic             m_slow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_prod_q  <= ProdW'(b_num_q) * ProdW'(RecipM);
      m_total_q <= b_total_q;
      m_inv_q   <= b_inv_q;
      m_fast_q  <= b_fast_q;
      m_slow_q  <= b_slow_q;
    end
  end

  // Stage C: clamp the divider, rounded numerator for the period
  logic [ProdW-1:0]  c_quo;
  logic [ProdW-1:0]  c_div_raw;
  logic              c_valid_q;
  logic [WideW-1:0]  c_num_q;
  logic [Div16W-1:0] c_div_q;
  logic              c_inv_q;
  logic              c_fast_q;
  logic              c_slow_q;

  assign c_quo     = m_prod_q >> RecipK;
  assign c_div_raw = (c_quo < ProdW'(MinDiv16)) ? ProdW'(MinDiv16) : c_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_num_q  <= WideW'(m_total_q) + WideW'(c_div_raw[Div16W-1:1]);
      c_div_q  <= c_div_raw[Div16W-1:0];
      c_inv_q  <= m_inv_q;
      c_fast_q <= m_fast_q;
      c_slow_q <= m_slow_q || (c_div_raw > ProdW'(MaxDiv16));
    end
  end

  localparam int unsigned Sb3W = Div16W + 3;

  logic             d3_valid;
  logic [WideW-1:0] d3_quo;
  logic [Sb3W-1:0]  d3_sb;

  pdw_div_pipe #(.NumW(WideW), .DenW(Div16W), .SbW(Sb3W)) u_div_period (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(c_valid_q), .num_i(c_num_q), .den_i(c_div_q),
    .sb_i({c_inv_q, c_fast_q, c_slow_q, c_div_q}),
    .valid_o(d3_valid), .quo_o(d3_quo), .sb_o(d3_sb)
  );

  // Stage D: clamp the period and pick the status
  logic [PerW-1:0]   period;
  logic [Div16W-1:0] d3_div;
  status_e           st;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [Div16W-1:0] out_div_q;
  logic [PerW-1:0]   out_wrap_q;

  assign d3_div = d3_sb[Div16W-1:0];

  always_comb begin
    if (d3_quo == '0) begin
      period = PerW'(1);
    end else if (d3_quo > WideW'(MaxPeriodCounts)) begin
      period = PerW'(MaxPeriodCounts);
    end else begin
      period = d3_quo[PerW-1:0];
    end
    if (d3_sb[Sb3W-1]) begin
      st = ST_INVALID;
    end else if (d3_sb[Sb3W-2]) begin
      st = ST_TOO_FAST;
    end else if (d3_sb[Sb3W-3]) begin
      st = ST_TOO_SLOW;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= st;
      out_div_q    <= (st == ST_OK) ? d3_div : '0;
      out_wrap_q   <= (st == ST_OK) ? period - PerW'(1) : '0;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.div_whole = out_div_q[Div16W-1:4];
  assign rsp_o.div_part  = out_div_q[3:0];
  assign rsp_o.wrap      = out_wrap_q;

  logic rsp_ok;
  logic rsp_err_dirty;

  assign rsp_ok        = rsp_o.valid && (rsp_o.status == ST_OK);
  assign rsp_err_dirty = rsp_o.valid && (rsp_o.status != ST_OK) &&
                         ({rsp_o.div_whole, rsp_o.div_part} != '0 || rsp_o.wrap != '0);

  `PDW_ASSERT_NEVER(a_err_fields_zero, rsp_err_dirty, "error result with non-zero fields")
  `PDW_ASSERT_NEVER(a_div_min, rsp_ok && out_div_q < Div16W'(MinDiv16), "divider below minimum")
  `PDW_ASSERT_NEVER(a_wrap_max, rsp_ok && out_wrap_q >= PerW'(MaxPeriodCounts), "wrap too big")
  `PDW_ASSERT(a_stall_keeps_pipe, !adv |=> ($stable(c_valid_q) && $stable(b_valid_q)), "stall moved")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM divider and wrap calculator testbench
// Sends target frequencies under several clock settings, predicts the
// divider, wrap and status of each request and compares them in order, with
// random idling on both sides and one long hold-off at the output.
// ----------------------------------------------------------------------------
module testbench;
  import pdw_pkg::*;

  localparam int unsigned Latency  = TotW + WideW + 5;
  localparam longint      CycleCap = 400000;

  typedef struct packed {
    status_e     status;
    logic [7:0]  div_whole;
    logic [3:0]  div_part;
    logic [15:0] wrap;
  } divider_set_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  pdw_target_if req_if ();
  pdw_result_if rsp_if ();

  pwm_divider_wrap_from_frequency u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic [31:0]  clock_setting;
  logic [31:0]  target_queue[$];
  divider_set_t expected_divs[$];
  int           mismatches;
  int           results_seen;
  int           sent_count;
  int           offered_count;
  int           idle_left_in;
  int           idle_left_out;
  int           hold_off_left;
  bit           idling_on;
  longint       cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out divider and wrap for one target at the current clock
  function automatic divider_set_t divide_target(logic [31:0] clk_hz, logic [31:0] tgt);
    divider_set_t res;
    logic [63:0]  total;
    logic [63:0]  div16;
    logic [63:0]  period;
    res = '0;
    if (clk_hz == 0 || tgt == 0) begin
      res.status = ST_INVALID;
      return res;
    end
    total = ({32'd0, clk_hz} * 64'd16 + {32'd0, tgt} / 2) / {32'd0, tgt};
    if (total < MinDiv16Default) begin
      res.status = ST_TOO_FAST;
      return res;
    end
    div16 = (total + MaxPeriodDefault - 1) / MaxPeriodDefault;
    if (div16 < MinDiv16Default) div16 = MinDiv16Default;
    if (div16 > MaxDiv16Default) begin
      res.status = ST_TOO_SLOW;
      return res;
    end
    period = (total + div16 / 2) / div16;
    if (period < 1) period = 1;
    if (period > MaxPeriodDefault) period = MaxPeriodDefault;
    res.status    = ST_OK;
    res.div_whole = div16[11:4];
    res.div_part  = div16[3:0];
    res.wrap      = 16'(period - 1);
    return res;
  endfunction

  // Record each accepted request at the edge that takes it
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_divs.push_back(divide_target(clock_setting, req_if.tgt_freq));
      sent_count++;
    end
  end

  // Driver: offer queued requests, idling in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || sent_count == offered_count) begin
        if (idle_left_in > 0) begin
          idle_left_in--;
          req_if.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
          idle_left_in = $urandom_range(1, 19) - 1;
          req_if.valid <= 1'b0;
        end else if (target_queue.size() > 0) begin
          req_if.valid    <= 1'b1;
          req_if.tgt_freq <= target_queue.pop_front();
          offered_count++;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_left_out > 0) begin
        idle_left_out--;
        rsp_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        idle_left_out = $urandom_range(1, 19) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    divider_set_t got;
    divider_set_t want;
    cycles++;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {status_e'(rsp_if.status), rsp_if.div_whole, rsp_if.div_part, rsp_if.wrap};
      results_seen++;
      if (expected_divs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_divs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: st %0d/%0d int %0d/%0d frac %0d/%0d wrap %0d/%0d",
                     want.status, got.status, want.div_whole, got.div_whole,
                     want.div_part, got.div_part, want.wrap, got.wrap);
        end
      end
    end
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(1, 100);
      2:       return $urandom_range(1, 20000);
      3:       return $urandom_range(1000, 2000000);
      4:       return clock_setting >> $urandom_range(0, 31);
      default: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
  endfunction

  task automatic drain();
    while (target_queue.size() > 0 || expected_divs.size() > 0 || req_if.valid)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic set_clock(logic [31:0] hz);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    clock_setting = hz;
  endtask

  initial begin
    logic [31:0] clocks[6];
    clocks = '{32'd125000000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd48000000, 32'd0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.tgt_freq = '0;
    rsp_if.ready = 1'b0;
    clock_setting = ClockHzReset;
    mismatches = 0;
    results_seen = 0;
    sent_count = 0;
    offered_count = 0;
    idle_left_in = 0;
    idle_left_out = 0;
    hold_off_left = 0;
    idling_on = 1'b1;
    cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Each clock setting, reset clock first: zero target, extremes, too fast, too slow, ok edges
    foreach (clocks[i]) begin
      if (i == 5) clocks[i] = $urandom();
      if (i > 0) set_clock(clocks[i]);
      target_queue = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd100, 32'd1907, 32'd1908,
                       32'd30, 32'd29, 32'd1000, 32'd125000000, 32'd7812500,
                       32'd7812501, 32'h5555_5555, 32'hAAAA_AAAA};
      if (i == 0) hold_off_left = 300;
      repeat (i == 0 ? 100 : 65) target_queue.push_back(pick_target());
      if (i == 4) idling_on = 1'b0;
      drain();
    end

    $display("sent %0d requests over six clock settings, %0d results checked",
             sent_count, results_seen);
    if (mismatches == 0 && expected_divs.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_divs.size());
      $display("testbench failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/pdw_pkg.sv
src/pdw_target_if.sv
src/pdw_result_if.sv
src/pdw_div_pipe.sv
src/pwm_divider_wrap_from_frequency.sv
test/testbench.sv
